// File: rtl/rmt_pkg.sv
// Package for the running median block: sizes, status codes and item kinds.
// Used by the interfaces, the sorted store RAM user and the top level.
package rmt_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int TM_W     = VALUE_W + 1;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_WRONG = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

// File: rtl/rmt_if.sv
// Valid/ready channel interfaces for the running median block.
// Depends on rmt_pkg for the field widths.
interface rmt_item_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [rmt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface rmt_result_if;
  logic                                valid;
  logic                                ready;
  logic        [1:0]                   status;
  logic signed [rmt_pkg::TM_W-1:0]     twice_median;

  modport source (output valid, output status, output twice_median, input ready);
  modport sink   (input valid, input status, input twice_median, output ready);
endinterface

// File: rtl/rmt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package is used.
module rmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/running_median_table.sv
// Top level of the running median block: sequencer around one sorted store RAM.
// Depends on rmt_pkg, the rmt_item_if / rmt_result_if interfaces and rmt_ram.
//
//   Channel   Direction  Words carried
//   item      in         kind (add / remove), value (signed 32 bits)
//   result    out        status (2 bits), twice_median (signed 33 bits)
//
// An add accepts the item, then walks down from the top entry, shifting larger
// entries up, and writes the value into the gap. A remove passes every entry
// once whether it hits or misses, since the scan and the shift together cover
// the whole set. The median is read from the single RAM read port: one middle
// entry for an odd count, two for an even one; S_DONE then hands the result to
// the output register. Reset (rst, synchronous) empties the set and drops any
// waiting result. A new item word is taken whenever the sequencer is idle, even
// while the last result word still waits in the output register; the sequencer
// then holds its finished result until the output register is free.
module running_median_table (
  input  logic          clk,
  input  logic          rst,
  rmt_item_if.sink      item,
  rmt_result_if.source  result
);

  localparam int AW = rmt_pkg::ADDR_W;
  localparam int CW = rmt_pkg::CNT_W;
  localparam int VW = rmt_pkg::VALUE_W;
  localparam int TW = rmt_pkg::TM_W;

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // waiting for an item word
    S_INS   = 8'b0000_0010,  // walk down from the top, shifting larger entries up
    S_SCAN  = 8'b0000_0100,  // search upward for the first equal entry
    S_SHIFT = 8'b0000_1000,  // close the gap left by the removed entry
    S_MEDRD = 8'b0001_0000,  // issue the first middle read
    S_MEDA  = 8'b0010_0000,  // first middle value arrives
    S_MEDB  = 8'b0100_0000,  // second middle value arrives (even count)
    S_DONE  = 8'b1000_0000   // hand the result to the output register
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         ptr, ptr_next;
  logic signed [VW-1:0]  val, val_next;
  logic signed [VW-1:0]  first, first_next;
  logic [1:0]            res_status, res_status_next;
  logic signed [TW-1:0]  res_tm, res_tm_next;

  // RAM port signals.
  logic                  we;
  logic [CW-1:0]         waddr_full;
  logic signed [VW-1:0]  wdata;
  logic [CW-1:0]         raddr_full;
  logic [VW-1:0]         rdata_raw;
  logic signed [VW-1:0]  rdata;

  logic [CW-1:0]         half;
  logic                  out_free;

  assign rdata    = rdata_raw;
  assign half     = count >> 1;
  assign out_free = !result.valid || result.ready;

  assign item.ready = (state == S_IDLE);

  rmt_ram #(
    .WIDTH (VW),
    .DEPTH (rmt_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata_raw)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    val_next        = val;
    first_next      = first;
    res_status_next = res_status;
    res_tm_next     = res_tm;
    we              = 1'b0;
    waddr_full      = ptr;
    wdata           = rdata;
    raddr_full      = '0;

    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          val_next = item.value;
          if (item.kind == rmt_pkg::KIND_ADD) begin
            if (count == CW'(rmt_pkg::CAPACITY)) begin
              // Store full: refuse the add.
              res_status_next = rmt_pkg::STATUS_FULL;
              res_tm_next     = '0;
              state_next      = S_DONE;
            end else begin
              // Start at the free slot just above the top entry.
              ptr_next   = count;
              raddr_full = count - CW'(1);
              state_next = S_INS;
            end
          end else begin
            ptr_next   = '0;
            raddr_full = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_INS: begin
        // rdata holds the entry just below slot ptr (when ptr is not zero).
        we = 1'b1;
        if (ptr != '0 && rdata > val) begin
          wdata      = rdata;
          raddr_full = ptr - CW'(2);
          ptr_next   = ptr - CW'(1);
        end else begin
          wdata      = val;
          count_next = count + CW'(1);
          state_next = S_MEDRD;
        end
      end

      S_SCAN: begin
        // rdata holds the entry at ptr; the next one is read regardless.
        raddr_full = ptr + CW'(1);
        if (ptr == count) begin
          res_status_next = rmt_pkg::STATUS_WRONG;
          res_tm_next     = '0;
          state_next      = S_DONE;
        end else if (rdata == val) begin
          state_next = S_SHIFT;
        end else begin
          ptr_next = ptr + CW'(1);
        end
      end

      S_SHIFT: begin
        // rdata holds the entry at ptr + 1, which moves down into ptr.
        if (ptr + CW'(1) < count) begin
          we         = 1'b1;
          wdata      = rdata;
          raddr_full = ptr + CW'(2);
          ptr_next   = ptr + CW'(1);
        end else begin
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            // Removing the last entry leaves the set empty: reported as wrong.
            res_status_next = rmt_pkg::STATUS_WRONG;
            res_tm_next     = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_MEDRD;
          end
        end
      end

      S_MEDRD: begin
        raddr_full = count[0] ? half : half - CW'(1);
        state_next = S_MEDA;
      end

      S_MEDA: begin
        first_next = rdata;
        if (count[0]) begin
          res_status_next = rmt_pkg::STATUS_OK;
          res_tm_next     = {rdata, 1'b0};
          state_next      = S_DONE;
        end else begin
          raddr_full = half;
          state_next = S_MEDB;
        end
      end

      S_MEDB: begin
        res_status_next = rmt_pkg::STATUS_OK;
        res_tm_next     = TW'(first) + TW'(rdata);
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    val        <= val_next;
    first      <= first_next;
    res_status <= res_status_next;
    res_tm     <= res_tm_next;
    if (state == S_DONE && out_free) begin
      result.status       <= res_status;
      result.twice_median <= res_tm;
    end
  end

endmodule
